### design/vrp_pkg.sv
package vrp_pkg;

  localparam int SPRITE_BYTES = 256;
  localparam int VIDEO_BYTES = 16384;
  localparam int SPRITE_AW = $clog2(SPRITE_BYTES);
  localparam int VIDEO_AW = $clog2(VIDEO_BYTES);

  // The palette area is held in two banks split on address bit 4, so that the
  // mirrored backdrop entries can be written in the same cycle.
  localparam int PALETTE_BANK_BYTES = 128;
  localparam int PALETTE_AW = $clog2(PALETTE_BANK_BYTES);

  localparam logic [1:0] OP_READ        = 2'd0;
  localparam logic [1:0] OP_WRITE       = 2'd1;
  localparam logic [1:0] OP_STATUS_LOAD = 2'd2;

  localparam logic [2:0] REG_CONTROL     = 3'd0;
  localparam logic [2:0] REG_MASK        = 3'd1;
  localparam logic [2:0] REG_STATUS      = 3'd2;
  localparam logic [2:0] REG_SPRITE_ADDR = 3'd3;
  localparam logic [2:0] REG_SPRITE_DATA = 3'd4;
  localparam logic [2:0] REG_SCROLL      = 3'd5;
  localparam logic [2:0] REG_ADDRESS     = 3'd6;
  localparam logic [2:0] REG_DATA        = 3'd7;

  localparam logic [7:0] ATTR_MASK = 8'hE3;
  localparam logic [VIDEO_AW-1:0] PALETTE_BASE = 14'h3F00;
  localparam logic [VIDEO_AW-1:0] PALETTE_SHADOW_OFFSET = 14'h1000;
  localparam logic [VIDEO_AW-1:0] PATTERN_LIMIT = 14'h2000;

  // Where the byte returned by a read comes from once memory data is back.
  typedef enum logic [2:0] {
    RD_NONE,
    RD_REG,
    RD_SPRITE,
    RD_BUFFER,
    RD_PALETTE
  } rd_kind_t;

  typedef struct packed {
    rd_kind_t   kind;
    logic [7:0] reg_data;
    logic       attr;
    logic       pal_hi;
    logic [14:0] vaddr;
    logic [14:0] taddr;
    logic [2:0] fine_x;
    logic       nmi_suppress;
  } issue_t;

  typedef struct packed {
    logic                  spr_we;
    logic [SPRITE_AW-1:0]  spr_addr;
    logic [7:0]            wdata;
    logic                  vid_we;
    logic [VIDEO_AW-1:0]   vid_waddr;
    logic [VIDEO_AW-1:0]   vid_raddr;
    logic [1:0]            pal_we;
    logic [PALETTE_AW-1:0] pal_index;
  } mem_cmd_t;

endpackage

### design/vrp_ram.sv
module vrp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### design/vrp_front.sv
module vrp_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic              cfg_we,
  input  logic              cfg_data,
  input  logic [1:0]        operation,
  input  logic [2:0]        register_index,
  input  logic [7:0]        write_data,
  input  logic              rendering_period,
  input  logic [7:0]        status_value,
  input  logic              hide_vblank_on_read,
  output vrp_pkg::issue_t   issue,
  output vrp_pkg::mem_cmd_t cmd
);

  logic       chr_ram_present;
  logic [7:0] control;
  logic [7:0] mask;
  logic [7:0] status;
  logic [7:0] sprite_address;
  logic       addr_latch;
  logic [14:0] temp_addr;
  logic [14:0] video_addr;
  logic [2:0] fine_x;

  logic [7:0] control_next;
  logic [7:0] mask_next;
  logic [7:0] status_next;
  logic [7:0] sprite_address_next;
  logic       addr_latch_next;
  logic [14:0] temp_addr_next;
  logic [14:0] video_addr_next;
  logic [2:0] fine_x_next;

  logic                         active;
  logic [vrp_pkg::VIDEO_AW-1:0] a;
  logic                         in_palette;

  // Standard coarse-X / fine-Y walk while rendering, plain step otherwise.
  function automatic logic [14:0] step_addr(input logic [14:0] v, input logic act,
                                            input logic inc32);
    logic [14:0] t;
    logic [4:0]  y;
    t = v;
    y = v[9:5];
    if (act) begin
      if (t[14:12] != 3'b111) begin
        t[14:12] = t[14:12] + 3'd1;
      end else begin
        t[14:12] = 3'd0;
        if (y == 5'd29) begin
          y = 5'd0;
          t[11] = ~t[11];
        end else if (y == 5'd31) begin
          y = 5'd0;
        end else begin
          y = y + 5'd1;
        end
        t[9:5] = y;
      end
      if (t[4:0] == 5'd31) begin
        t[4:0] = 5'd0;
        t[10] = ~t[10];
      end else begin
        t[4:0] = t[4:0] + 5'd1;
      end
    end else begin
      t = v + (inc32 ? 15'd32 : 15'd1);
    end
    return t;
  endfunction

  assign active = rendering_period && (mask[3] || mask[4]);
  assign a = video_addr[vrp_pkg::VIDEO_AW-1:0];
  assign in_palette = (a >= vrp_pkg::PALETTE_BASE);

  always_comb begin
    control_next        = control;
    mask_next           = mask;
    status_next         = status;
    sprite_address_next = sprite_address;
    addr_latch_next     = addr_latch;
    temp_addr_next      = temp_addr;
    video_addr_next     = video_addr;
    fine_x_next         = fine_x;

    issue.kind         = vrp_pkg::RD_NONE;
    issue.reg_data     = 8'd0;
    issue.attr         = (sprite_address[1:0] == 2'b10);
    issue.pal_hi       = a[4];
    issue.nmi_suppress = 1'b0;

    cmd.spr_we    = 1'b0;
    cmd.spr_addr  = sprite_address;
    cmd.wdata     = write_data;
    cmd.vid_we    = 1'b0;
    cmd.vid_waddr = a;
    cmd.vid_raddr = in_palette ? (a - vrp_pkg::PALETTE_SHADOW_OFFSET) : a;
    cmd.pal_we    = 2'b00;
    cmd.pal_index = {a[7:5], a[3:0]};

    unique case (operation)
      vrp_pkg::OP_STATUS_LOAD: begin
        status_next = status_value;
      end
      vrp_pkg::OP_READ: begin
        unique case (register_index)
          vrp_pkg::REG_STATUS: begin
            issue.kind         = vrp_pkg::RD_REG;
            issue.reg_data     = hide_vblank_on_read ? {1'b0, status[6:0]} : status;
            issue.nmi_suppress = 1'b1;
            status_next        = {1'b0, status[6:0]};
            addr_latch_next    = 1'b0;
          end
          vrp_pkg::REG_SPRITE_DATA: begin
            issue.kind = vrp_pkg::RD_SPRITE;
            if (active) begin
              sprite_address_next = sprite_address + 8'd1;
            end
          end
          vrp_pkg::REG_DATA: begin
            issue.kind      = in_palette ? vrp_pkg::RD_PALETTE : vrp_pkg::RD_BUFFER;
            video_addr_next = step_addr(video_addr, active, control[2]);
          end
          default: begin
          end
        endcase
      end
      vrp_pkg::OP_WRITE: begin
        unique case (register_index)
          vrp_pkg::REG_CONTROL: begin
            control_next          = write_data;
            temp_addr_next[11:10] = write_data[1:0];
          end
          vrp_pkg::REG_MASK: begin
            mask_next = write_data;
          end
          vrp_pkg::REG_SPRITE_ADDR: begin
            sprite_address_next = write_data;
          end
          vrp_pkg::REG_SPRITE_DATA: begin
            if (active) begin
              sprite_address_next = sprite_address + 8'd4;
            end else begin
              cmd.spr_we          = 1'b1;
              sprite_address_next = sprite_address + 8'd1;
            end
          end
          vrp_pkg::REG_SCROLL: begin
            if (!addr_latch) begin
              temp_addr_next[4:0] = write_data[7:3];
              fine_x_next         = write_data[2:0];
            end else begin
              temp_addr_next[9:5]   = write_data[7:3];
              temp_addr_next[14:12] = write_data[2:0];
            end
            addr_latch_next = ~addr_latch;
          end
          vrp_pkg::REG_ADDRESS: begin
            if (!addr_latch) begin
              temp_addr_next[14:8] = {1'b0, write_data[5:0]};
            end else begin
              temp_addr_next[7:0] = write_data;
              video_addr_next     = {temp_addr[14:8], write_data};
            end
            addr_latch_next = ~addr_latch;
          end
          vrp_pkg::REG_DATA: begin
            if (in_palette) begin
              // Backdrop entries are written to both banks, so each matches its mirror.
              cmd.pal_we[0] = !a[4] || (a[3:0] == 4'd0);
              cmd.pal_we[1] = a[4] || (a[3:0] == 4'd0);
            end else begin
              cmd.vid_we = (a >= vrp_pkg::PATTERN_LIMIT) || chr_ram_present;
            end
            video_addr_next = step_addr(video_addr, active, control[2]);
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase

    cmd.spr_we    = cmd.spr_we && accept;
    cmd.vid_we    = cmd.vid_we && accept;
    cmd.pal_we    = cmd.pal_we & {2{accept}};
    issue.vaddr   = video_addr_next;
    issue.taddr   = temp_addr_next;
    issue.fine_x  = fine_x_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chr_ram_present <= 1'b0;
    end else if (cfg_we) begin
      chr_ram_present <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      control        <= 8'd0;
      mask           <= 8'd0;
      status         <= 8'd0;
      sprite_address <= 8'd0;
      addr_latch     <= 1'b0;
      temp_addr      <= 15'd0;
      video_addr     <= 15'd0;
      fine_x         <= 3'd0;
    end else if (accept) begin
      control        <= control_next;
      mask           <= mask_next;
      status         <= status_next;
      sprite_address <= sprite_address_next;
      addr_latch     <= addr_latch_next;
      temp_addr      <= temp_addr_next;
      video_addr     <= video_addr_next;
      fine_x         <= fine_x_next;
    end
  end

endmodule

### design/vrp_back.sv
module vrp_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  vrp_pkg::issue_t issue,
  input  logic [7:0]      spr_rdata,
  input  logic [7:0]      vid_rdata,
  input  logic [7:0]      pal_rdata0,
  input  logic [7:0]      pal_rdata1,
  output logic            ready,
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [47:0]     m_tdata   // read_data, current_vram_address, temp_address,
                                    // fine_x_scroll, nmi_suppress, zero fill
);

  logic            s1_valid;
  vrp_pkg::issue_t s1;
  logic            advance;
  logic [7:0]      read_buffer;
  logic [7:0]      rd;
  logic            load_buffer;

  assign advance = s1_valid && (!m_tvalid || m_tready);
  assign ready   = !s1_valid || advance;
  assign load_buffer = (s1.kind == vrp_pkg::RD_BUFFER) || (s1.kind == vrp_pkg::RD_PALETTE);

  // Memory data is valid for the whole time an item sits here, because the
  // memories are only read on a transfer.
  always_comb begin
    case (s1.kind)
      vrp_pkg::RD_REG:     rd = s1.reg_data;
      vrp_pkg::RD_SPRITE:  rd = s1.attr ? (spr_rdata & vrp_pkg::ATTR_MASK) : spr_rdata;
      vrp_pkg::RD_BUFFER:  rd = read_buffer;
      vrp_pkg::RD_PALETTE: rd = s1.pal_hi ? pal_rdata1 : pal_rdata0;
      default:             rd = 8'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      m_tvalid    <= 1'b0;
      read_buffer <= 8'd0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        m_tvalid <= 1'b1;
        if (load_buffer) begin
          read_buffer <= vid_rdata;
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= issue;
    end
    if (advance) begin
      m_tdata <= {6'd0, s1.nmi_suppress, s1.fine_x, s1.taddr, s1.vaddr, rd};
    end
  end

  a_accept_fills : assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("accepted item did not reach the memory stage");

  a_stall_holds : assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !advance) |=> (s1_valid && $stable(s1)))
    else $error("stalled memory-stage item changed");

  a_buffer_source : assert property (@(posedge clk) disable iff (rst)
    ($past(!rst) && !$stable(read_buffer)) |->
      $past(advance && ((s1.kind == vrp_pkg::RD_BUFFER) || (s1.kind == vrp_pkg::RD_PALETTE))))
    else $error("read buffer changed without a data-port read");

endmodule

### design/video_register_port.sv
// CPU register port of a picture processor: eight registers (control, mask,
// status, sprite address, sprite data, scroll, address, data) behind a
// streaming request channel, one result per request. A request is taken
// whenever the memory stage is empty or its item moves to the output register
// in the same cycle, so with the result side ready the sustained rate is one
// request per clock. Its result is registered in the memory stage, where the
// registered read of the sprite, video and palette memories comes back, and
// then in the output register that drives the master side. Two results can
// wait while the result side stalls, and only then is s_tready low.
// Sprite memory is 256 bytes, video memory a flat 16K, and the palette area is
// held in two 128-byte banks so backdrop mirroring writes both in the same cycle.
// Memories are not cleared after reset; reading a never-written byte returns
// an arbitrary value. The pattern-area write enable is set through cfg_we.
module video_register_port (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_data,   // chr_ram_present
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,    // write_data, rendering_period, status_value,
                                  // hide_vblank_on_read, zero fill
  input  logic [4:0]  s_tuser,    // operation, register_index
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata     // read_data, current_vram_address, temp_address,
                                  // fine_x_scroll, nmi_suppress, zero fill
);

  logic              accept;
  vrp_pkg::issue_t   issue;
  vrp_pkg::mem_cmd_t cmd;
  logic [7:0]        spr_rdata;
  logic [7:0]        vid_rdata;
  logic [7:0]        pal_rdata0;
  logic [7:0]        pal_rdata1;

  assign accept = s_tvalid && s_tready;

  vrp_front u_front (
    .clk                 (clk),
    .rst                 (rst),
    .accept              (accept),
    .cfg_we              (cfg_we),
    .cfg_data            (cfg_data),
    .operation           (s_tuser[1:0]),
    .register_index      (s_tuser[4:2]),
    .write_data          (s_tdata[7:0]),
    .rendering_period    (s_tdata[8]),
    .status_value        (s_tdata[16:9]),
    .hide_vblank_on_read (s_tdata[17]),
    .issue               (issue),
    .cmd                 (cmd)
  );

  vrp_ram #(.WIDTH(8), .DEPTH(vrp_pkg::SPRITE_BYTES)) u_sprite_ram (
    .clk     (clk),
    .wr_en   (cmd.spr_we),
    .wr_addr (cmd.spr_addr),
    .wr_data (cmd.wdata),
    .rd_en   (accept),
    .rd_addr (cmd.spr_addr),
    .rd_data (spr_rdata)
  );

  vrp_ram #(.WIDTH(8), .DEPTH(vrp_pkg::VIDEO_BYTES)) u_video_ram (
    .clk     (clk),
    .wr_en   (cmd.vid_we),
    .wr_addr (cmd.vid_waddr),
    .wr_data (cmd.wdata),
    .rd_en   (accept),
    .rd_addr (cmd.vid_raddr),
    .rd_data (vid_rdata)
  );

  vrp_ram #(.WIDTH(8), .DEPTH(vrp_pkg::PALETTE_BANK_BYTES)) u_palette_lo (
    .clk     (clk),
    .wr_en   (cmd.pal_we[0]),
    .wr_addr (cmd.pal_index),
    .wr_data (cmd.wdata),
    .rd_en   (accept),
    .rd_addr (cmd.pal_index),
    .rd_data (pal_rdata0)
  );

  vrp_ram #(.WIDTH(8), .DEPTH(vrp_pkg::PALETTE_BANK_BYTES)) u_palette_hi (
    .clk     (clk),
    .wr_en   (cmd.pal_we[1]),
    .wr_addr (cmd.pal_index),
    .wr_data (cmd.wdata),
    .rd_en   (accept),
    .rd_addr (cmd.pal_index),
    .rd_data (pal_rdata1)
  );

  vrp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .issue      (issue),
    .spr_rdata  (spr_rdata),
    .vid_rdata  (vid_rdata),
    .pal_rdata0 (pal_rdata0),
    .pal_rdata1 (pal_rdata1),
    .ready      (s_tready),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

endmodule
